>>> hw/rtl/avgpool_pkg.sv
// Shared types and constants for the average pooling stream unit.
// Used by every module under hw/rtl; depends on nothing else.
package avgpool_pkg;

  // Fixed field widths of the stream and register words.
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 20;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Row counting is limited independently of the line store depth.
  localparam int ROW_LIMIT = 64;
  localparam int ROW_W     = 6;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'd1;

  // Register reset values.
  localparam logic [DIM_W-1:0] MAP_WIDTH_RST  = 7'd24;
  localparam logic [DIM_W-1:0] MAP_HEIGHT_RST = 7'd24;

  // Decoded position of one accepted sample inside the pooling grid.
  typedef struct packed {
    logic store;     // sample closes a window row: update the line store
    logic first_row; // window row is the top row of its window
    logic emit;      // window row is the bottom row: a result follows
    logic last;      // window is the last whole window of the frame
  } pos_flags_t;

endpackage

>>> hw/rtl/average_pooling_stream_unit.sv
// Average pooling stream unit: non-overlapping POOL x POOL window means.
// A result word passes the line store, magnitude, divider and output
// registers after its window's last sample is accepted. One sample word per
// cycle unless the output stalls; the line store has one read port,
// read at accept, and one write port, written one stage later.
// Reset clears counters and valid flags and sets both map sizes to 24; the
// line store is not cleared, every entry is written before it is read.
module average_pooling_stream_unit #(
  parameter int POOL      = 2,
  parameter int MAX_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration: index 0 is map_width, index 1 is map_height.
  input  logic                                  cfg_we,
  input  logic [avgpool_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [avgpool_pkg::DIM_W-1:0]         cfg_data,
  // Input stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [15:0]                           s_tdata,  // [15:0] sample
  // Output stream.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [15:0]                           m_tdata,  // [15:0] average
  output logic                                  m_tlast   // frame_last
);
  import avgpool_pkg::*;

  localparam int WCW = (MAX_WIDTH / POOL) > 1 ? $clog2(MAX_WIDTH / POOL) : 1;

  logic                    accept;
  logic [WCW-1:0]          rd_addr;
  pos_flags_t              flags;
  logic signed [SUM_W-1:0] row_sum;

  logic                    sum_valid;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic                    sum_last;
  logic                    sum_ready;

  logic                    quot_valid;
  logic                    quot_neg;
  logic [SAMPLE_W-1:0]     quot;
  logic                    quot_last;
  logic                    quot_ready;

  // The output register takes a new word whenever it is empty or its
  // current word is taken in the same cycle, so the stream never gaps.
  assign quot_ready = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;

  // Counters, window decode and horizontal sums of each window row.
  avgpool_ctrl #(
    .POOL      (POOL),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample    ($signed(s_tdata)),
    .rd_addr   (rd_addr),
    .flags     (flags),
    .row_sum   (row_sum)
  );

  // Line store: one partial sum per window column, folded row by row.
  avgpool_line #(
    .POOL      (POOL),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rd_addr   (rd_addr),
    .flags     (flags),
    .row_sum   (row_sum),
    .in_ready  (s_tready),
    .sum_valid (sum_valid),
    .sum_neg   (sum_neg),
    .sum_mag   (sum_mag),
    .sum_last  (sum_last),
    .sum_ready (sum_ready)
  );

  // Window sum magnitude divided by POOL*POOL.
  avgpool_div #(
    .POOL (POOL)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .sum_valid  (sum_valid),
    .sum_neg    (sum_neg),
    .sum_mag    (sum_mag),
    .sum_last   (sum_last),
    .sum_ready  (sum_ready),
    .quot_valid (quot_valid),
    .quot_neg   (quot_neg),
    .quot       (quot),
    .quot_last  (quot_last),
    .quot_ready (quot_ready)
  );

  // Restoring the sign of the quotient gives truncation toward zero.
  always_ff @(posedge clk) begin
    if (quot_valid && quot_ready) begin
      m_tdata <= quot_neg ? (-quot) : quot;
      m_tlast <= quot_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (quot_valid && quot_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/avgpool_ctrl.sv
// Position tracking for the average pooling stream unit: map size registers,
// column and row counters, window decode and the horizontal accumulator.
// Depends on avgpool_pkg.
module avgpool_ctrl #(
  parameter int POOL      = 2,
  parameter int MAX_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [avgpool_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [avgpool_pkg::DIM_W-1:0]         cfg_data,
  input  logic                                  accept,
  input  logic signed [avgpool_pkg::SAMPLE_W-1:0] sample,
  output logic [((MAX_WIDTH/POOL) > 1 ? $clog2(MAX_WIDTH/POOL) : 1)-1:0] rd_addr,
  output avgpool_pkg::pos_flags_t               flags,
  output logic signed [avgpool_pkg::SUM_W-1:0]  row_sum
);
  import avgpool_pkg::*;

  localparam int WCW   = (MAX_WIDTH / POOL) > 1 ? $clog2(MAX_WIDTH / POOL) : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PW    = $clog2(POOL);
  localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int RX_W  = DIM_W + 1;

  localparam logic [CMP_W-1:0] MAXW_C   = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W:0]   POOL_X   = (CMP_W + 1)'(POOL);
  localparam logic [RX_W-1:0]  POOL_R   = RX_W'(POOL);
  localparam logic [DIM_W-1:0] ROWLIM_C = DIM_W'(ROW_LIMIT);
  localparam logic [PW-1:0]    PH_LAST  = PW'(POOL - 1);

  logic [DIM_W-1:0]          map_width;
  logic [DIM_W-1:0]          map_height;
  logic [CW-1:0]             col;
  logic [PW-1:0]             pcol;
  logic [WCW-1:0]            wcol;
  logic [ROW_W-1:0]          row;
  logic [PW-1:0]             prow;
  logic signed [SUM_W-1:0]   row_acc;

  logic [CMP_W-1:0]          w_eff;
  logic [DIM_W-1:0]          h_eff;
  logic [CW-1:0]             col_base;
  logic [ROW_W-1:0]          row_base;
  logic [CMP_W:0]            col_room;
  logic [RX_W-1:0]           row_room;
  logic                      col_in;
  logic                      row_in;
  logic                      col_last_win;
  logic                      row_last_win;
  logic                      col_end;
  logic                      row_end;
  logic                      pc_last;
  logic                      pr_last;
  logic                      in_win;

  // Effective map size: zero counts as one, wide and tall maps are clamped.
  always_comb begin
    if (map_width == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(map_width) > MAXW_C) begin
      w_eff = MAXW_C;
    end else begin
      w_eff = CMP_W'(map_width);
    end
    if (map_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (map_height > ROWLIM_C) begin
      h_eff = ROWLIM_C;
    end else begin
      h_eff = map_height;
    end
  end

  // A window is whole when its first column plus POOL fits inside the map.
  // It is the last whole one when a further POOL would not fit.
  always_comb begin
    col_base     = col - CW'(pcol);
    row_base     = row - ROW_W'(prow);
    col_room     = (CMP_W + 1)'(col_base) + POOL_X;
    row_room     = RX_W'(row_base) + POOL_R;
    col_in       = col_room <= (CMP_W + 1)'(w_eff);
    row_in       = row_room <= RX_W'(h_eff);
    col_last_win = (col_room + POOL_X) > (CMP_W + 1)'(w_eff);
    row_last_win = (row_room + POOL_R) > RX_W'(h_eff);
    col_end      = ((CMP_W + 1)'(col) + (CMP_W + 1)'(1)) >= (CMP_W + 1)'(w_eff);
    row_end      = (RX_W'(row) + RX_W'(1)) >= RX_W'(h_eff);
    pc_last      = pcol == PH_LAST;
    pr_last      = prow == PH_LAST;
    in_win       = col_in && row_in;
  end

  always_comb begin
    if (pcol == '0) begin
      row_sum = SUM_W'(sample);
    end else begin
      row_sum = row_acc + SUM_W'(sample);
    end
  end

  assign rd_addr         = wcol;
  assign flags.store     = in_win && pc_last;
  assign flags.first_row = prow == '0;
  assign flags.emit      = pr_last;
  assign flags.last      = col_last_win && row_last_win;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_WIDTH_RST;
      map_height <= MAP_HEIGHT_RST;
      col        <= '0;
      pcol       <= '0;
      wcol       <= '0;
      row        <= '0;
      prow       <= '0;
      row_acc    <= '0;
    end else if (cfg_we) begin
      // Any register write restarts the frame.
      case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
      col     <= '0;
      pcol    <= '0;
      wcol    <= '0;
      row     <= '0;
      prow    <= '0;
      row_acc <= '0;
    end else if (accept) begin
      if (in_win) begin
        row_acc <= row_sum;
      end
      if (col_end) begin
        col  <= '0;
        pcol <= '0;
        wcol <= '0;
        if (row_end) begin
          row  <= '0;
          prow <= '0;
        end else begin
          row  <= row + ROW_W'(1);
          prow <= pr_last ? '0 : prow + PW'(1);
        end
      end else begin
        col <= col + CW'(1);
        if (pc_last) begin
          pcol <= '0;
          wcol <= wcol + WCW'(1);
        end else begin
          pcol <= pcol + PW'(1);
        end
      end
    end
  end

endmodule

>>> hw/rtl/avgpool_line.sv
// Line store of partial window sums for the average pooling stream unit,
// with the read-modify-write stage and the magnitude stage after it.
// Depends on avgpool_pkg.
module avgpool_line #(
  parameter int POOL      = 2,
  parameter int MAX_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic [((MAX_WIDTH/POOL) > 1 ? $clog2(MAX_WIDTH/POOL) : 1)-1:0] rd_addr,
  input  avgpool_pkg::pos_flags_t               flags,
  input  logic signed [avgpool_pkg::SUM_W-1:0]  row_sum,
  output logic                                  in_ready,
  output logic                                  sum_valid,
  output logic                                  sum_neg,
  output logic [avgpool_pkg::SUM_W-1:0]         sum_mag,
  output logic                                  sum_last,
  input  logic                                  sum_ready
);
  import avgpool_pkg::*;

  localparam int WCW       = (MAX_WIDTH / POOL) > 1 ? $clog2(MAX_WIDTH / POOL) : 1;
  localparam int MEM_DEPTH = 1 << WCW;

  logic signed [SUM_W-1:0] line_mem [MEM_DEPTH];

  logic                    s1_valid;
  pos_flags_t              s1_flags;
  logic [WCW-1:0]          s1_addr;
  logic signed [SUM_W-1:0] s1_row_sum;
  logic signed [SUM_W-1:0] rd_data;

  logic signed [SUM_W-1:0] line_sum;
  logic                    s1_adv;
  logic                    s2_ready;

  assign s2_ready = !sum_valid || sum_ready;
  assign s1_adv   = s1_valid && (!s1_flags.emit || s2_ready);
  assign in_ready = !s1_valid || s1_adv;

  // The top row of a window starts a fresh partial sum.
  assign line_sum = s1_flags.first_row ? s1_row_sum : rd_data + s1_row_sum;

  // The same entry is read again only one map row later, well after the
  // earlier item has written it back.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data    <= line_mem[rd_addr];
      s1_flags   <= flags;
      s1_addr    <= rd_addr;
      s1_row_sum <= row_sum;
    end
    if (s1_adv) begin
      line_mem[s1_addr] <= line_sum;
    end
    if (s1_adv && s1_flags.emit) begin
      sum_neg  <= line_sum[SUM_W-1];
      sum_mag  <= line_sum[SUM_W-1] ? $unsigned(-line_sum) : $unsigned(line_sum);
      sum_last <= s1_flags.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= flags.store;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1_flags.emit) begin
        sum_valid <= 1'b1;
      end else if (sum_ready) begin
        sum_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/avgpool_div.sv
// Division of a window sum magnitude by POOL*POOL through a multiply by a
// rounded-up reciprocal, exact for every 20-bit magnitude.
// Depends on avgpool_pkg.
module avgpool_div #(
  parameter int POOL = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sum_valid,
  input  logic                                  sum_neg,
  input  logic [avgpool_pkg::SUM_W-1:0]         sum_mag,
  input  logic                                  sum_last,
  output logic                                  sum_ready,
  output logic                                  quot_valid,
  output logic                                  quot_neg,
  output logic [avgpool_pkg::SAMPLE_W-1:0]      quot,
  output logic                                  quot_last,
  input  logic                                  quot_ready
);
  import avgpool_pkg::*;

  localparam int DIVISOR = POOL * POOL;
  localparam int DIV_SH  = $clog2(DIVISOR);
  localparam int SHIFT   = SUM_W + DIV_SH;
  localparam int MULW    = SUM_W + 1;
  localparam int PROD_W  = SUM_W + MULW;
  localparam longint RECIP = ((64'sd1 <<< SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam logic [MULW-1:0] RECIP_C = MULW'(RECIP);

  logic [PROD_W-1:0] product;
  logic              take;

  assign product   = PROD_W'(sum_mag) * PROD_W'(RECIP_C);
  assign sum_ready = !quot_valid || quot_ready;
  assign take      = sum_valid && sum_ready;

  always_ff @(posedge clk) begin
    if (take) begin
      quot      <= product[SHIFT +: SAMPLE_W];
      quot_neg  <= sum_neg;
      quot_last <= sum_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quot_valid <= 1'b0;
    end else if (take) begin
      quot_valid <= 1'b1;
    end else if (quot_ready) begin
      quot_valid <= 1'b0;
    end
  end

endmodule

>>> bench/tb_average_pooling_stream_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for average_pooling_stream_unit: 2x2 window means over a raster stream.
// Depends on avgpool_pkg and the unit itself; reads no files and needs no arguments.
module tb_average_pooling_stream_unit;
  import avgpool_pkg::*;

  localparam int POOL             = 2;
  localparam int MAX_WIDTH        = 64;
  localparam int LINE_DEPTH       = MAX_WIDTH / POOL;
  localparam int ITEM_TARGET      = 2000;
  localparam int TAIL_ITEMS       = 300;
  // A window's mean passes the unit's pipeline registers after the window
  // closes; the settle wait allows for that before the unit counts as idle.
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 4000;

  // One pooled result word as it should appear on the master side.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       frame_last;
  } window_mean_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAP_WIDTH;
  logic [DIM_W-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [15:0]          m_tdata;
  logic                 m_tlast;

  // Window means that the unit still owes, oldest first.
  window_mean_t window_means_q[$];

  // Shadow of the pooling grid: register values, partial window sums per
  // window column, the running sum of the current window row and the
  // position of the next sample.
  logic [DIM_W-1:0]        grid_width;
  logic [DIM_W-1:0]        grid_height;
  logic signed [SUM_W-1:0] line_sums [LINE_DEPTH];
  logic signed [SUM_W-1:0] row_sum;
  int                      col_pos;
  int                      row_pos;

  // Stimulus controls shared by the test tasks and the two driving processes.
  bit sender_idling   = 1'b1;
  bit receiver_idling = 1'b1;
  bit hold_request    = 1'b0;

  int samples_sent    = 0;
  int means_checked   = 0;
  int register_writes = 0;
  int input_stalls    = 0;
  int quiet_cycles    = 0;
  int errors          = 0;

  average_pooling_stream_unit #(
    .POOL      (POOL),
    .MAX_WIDTH (MAX_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The unit treats a size of zero as one and anything above the line store
  // or row counter range as that range.
  function automatic int clamp_size(input int size, input int limit);
    if (size < 1) return 1;
    if (size > limit) return limit;
    return size;
  endfunction

  // Register writes and reset both start a new frame; the line store keeps
  // its contents, since every entry is written again before it is read.
  function automatic void restart_grid();
    row_sum = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Adds one accepted sample to the shadow grid and queues the window mean
  // if the sample is the bottom-right corner of a whole window. Samples in
  // trailing columns or rows only move the position.
  function automatic void accumulate_sample(input logic signed [SAMPLE_W-1:0] value);
    int           w;
    int           h;
    int           win_cols;
    int           win_rows;
    int           wc;
    window_mean_t mean;
    w        = clamp_size(grid_width, MAX_WIDTH);
    h        = clamp_size(grid_height, ROW_LIMIT);
    win_cols = w / POOL;
    win_rows = h / POOL;
    if (col_pos < win_cols * POOL && row_pos < win_rows * POOL) begin
      wc = col_pos / POOL;
      if (col_pos % POOL == 0) begin
        row_sum = value;
      end else begin
        row_sum = row_sum + value;
      end
      if (col_pos % POOL == POOL - 1) begin
        if (row_pos % POOL == 0) begin
          line_sums[wc] = row_sum;
        end else begin
          line_sums[wc] = line_sums[wc] + row_sum;
        end
        if (row_pos % POOL == POOL - 1) begin
          // Signed division truncates toward zero, as the unit must.
          mean.average    = line_sums[wc] / (POOL * POOL);
          mean.frame_last = (wc == win_cols - 1) && (row_pos / POOL == win_rows - 1);
          window_means_q.push_back(mean);
        end
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Everything is observed at the rising edge, where the handshakes count.
  // Input words are predicted before output words are checked; the unit's
  // latency keeps a word from being both predicted and due in one cycle.
  always @(posedge clk) begin : scoreboard
    window_mean_t expected;
    if (rst) begin
      grid_width  = MAP_WIDTH_RST;
      grid_height = MAP_HEIGHT_RST;
      restart_grid();
    end else begin
      if (cfg_we) begin
        register_writes++;
        case (cfg_index)
          REG_MAP_WIDTH: begin
            grid_width = cfg_data;
            restart_grid();
          end
          REG_MAP_HEIGHT: begin
            grid_height = cfg_data;
            restart_grid();
          end
          default: ;
        endcase
      end
      if (s_tvalid && !s_tready) input_stalls++;
      if (s_tvalid && s_tready) accumulate_sample(s_tdata);
      if (m_tvalid && m_tready) begin
        if (window_means_q.size() == 0) begin
          errors++;
          $display("%0t ns: window mean with nothing expected, expected none, actual %0d last %0b",
                   $time, $signed(m_tdata), m_tlast);
        end else begin
          expected = window_means_q.pop_front();
          means_checked++;
          if (m_tdata !== expected.average) begin
            errors++;
            $display("%0t ns: average mismatch, expected %0d, actual %0d",
                     $time, expected.average, $signed(m_tdata));
          end
          if (m_tlast !== expected.frame_last) begin
            errors++;
            $display("%0t ns: frame_last mismatch, expected %0b, actual %0b",
                     $time, expected.frame_last, m_tlast);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Ends the run if no word moves on either side for too long. The longest
  // legal silence is the long receiver hold-off, far below the limit.
  initial begin : watchdog
    wait (!rst);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t ns: no word accepted for %0d cycles, %0d window means still owed",
             $time, WATCHDOG_LIMIT, window_means_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: ready most of the time, with random stall bursts while idling
  // is on, and one long hold-off on request that lets the unit fill up.
  initial begin : receiver
    int hold_count;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        for (hold_count = 1; hold_count < LONG_HOLD_CYCLES; hold_count++) @(negedge clk);
        hold_request = 1'b0;
      end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offers one sample word and returns at the falling edge after it was
  // taken, with tvalid still high so that back-to-back words need no gap.
  task automatic send_sample(input logic [15:0] value);
    if (sender_idling && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  // Mostly uniform 16-bit samples, with the range ends and the values around
  // zero mixed in often.
  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_sample(random_sample());
  endtask

  // Stops offering words, waits for every owed mean and then lets the
  // pipeline run empty, so that trailing samples are through as well.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (window_means_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[DIM_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_map_size(input int width, input int height);
    quiesce();
    write_register(REG_MAP_WIDTH, width);
    write_register(REG_MAP_HEIGHT, height);
  endtask

  // The sizes after reset must be 24 by 24 without any register write.
  task automatic test_reset_frame();
    send_random(24 * 24);
  endtask

  // Single 2x2 maps: saturated windows of both signs and sums that show
  // truncation toward zero rather than flooring.
  task automatic test_extreme_windows();
    set_map_size(2, 2);
    repeat (4) send_sample(16'h7FFF);
    repeat (4) send_sample(16'h8000);
    send_sample(16'hFFFF); send_sample(16'h0000); send_sample(16'h0000); send_sample(16'h0000);
    send_sample(16'hFFFB); send_sample(16'h0000); send_sample(16'h0000); send_sample(16'h0000);
    send_sample(16'hFFFD); send_sample(16'h0001); send_sample(16'h0000); send_sample(16'h0000);
    send_sample(16'h0007); send_sample(16'h0000); send_sample(16'h0000); send_sample(16'h0000);
    send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h7FFF); send_sample(16'h7FFF);
  endtask

  // Odd sizes leave a trailing column and row that must be swallowed.
  task automatic test_trailing_edges();
    set_map_size(5, 5);
    send_random(2 * 25);
    set_map_size(3, 7);
    send_random(2 * 21);
  endtask

  // Sizes of zero and one, and a size of one in either direction, give no
  // windows at all.
  task automatic test_degenerate_sizes();
    set_map_size(0, 7);
    send_random(14);
    set_map_size(1, 4);
    send_random(8);
    set_map_size(6, 0);
    send_random(12);
    set_map_size(6, 1);
    send_random(12);
  endtask

  // Full-range register values clamp to the largest map in either direction;
  // the other direction stays small to keep the frames short.
  task automatic test_largest_sizes();
    set_map_size(127, 2);
    send_random(64 * 2);
    set_map_size(64, 3);
    send_random(64 * 3);
    set_map_size(2, 127);
    send_random(2 * 64);
  endtask

  // A write to either register in the middle of a frame restarts it, even
  // when the value does not change.
  task automatic test_restart_on_write();
    set_map_size(6, 4);
    send_random(9);
    quiesce();
    write_register(REG_MAP_HEIGHT, 4);
    send_random(24);
    send_random(7);
    quiesce();
    write_register(REG_MAP_WIDTH, 6);
    send_random(24);
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // unit has to fill up and stall its input.
  task automatic test_output_hold();
    set_map_size(4, 4);
    sender_idling = 1'b0;
    hold_request  = 1'b1;
    send_random(48);
    sender_idling = 1'b1;
    quiesce();
  endtask

  // The sender stops in the middle of a frame until every mean has arrived.
  task automatic test_sender_drain();
    set_map_size(8, 4);
    send_random(20);
    quiesce();
    send_random(12);
  endtask

  // Random sizes with whole frames and a ragged partial frame at the end,
  // which the next register write has to cut off cleanly.
  task automatic test_random_frames();
    int width;
    int height;
    int frame_words;
    int frames;
    while (samples_sent < ITEM_TARGET - TAIL_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          width  = $urandom_range(0, 127);
          height = $urandom_range(0, 4);
        end
        1: begin
          width  = $urandom_range(0, 4);
          height = $urandom_range(0, 127);
        end
        default: begin
          width  = $urandom_range(2, 12);
          height = $urandom_range(2, 12);
        end
      endcase
      set_map_size(width, height);
      sender_idling   = ($urandom_range(0, 3) != 0);
      receiver_idling = ($urandom_range(0, 3) != 0);
      frame_words = clamp_size(width, MAX_WIDTH) * clamp_size(height, ROW_LIMIT);
      frames      = (frame_words > 100) ? 1 : $urandom_range(1, 3);
      send_random(frames * frame_words + $urandom_range(0, clamp_size(width, MAX_WIDTH)));
    end
  endtask

  // Back-to-back words on both sides to finish.
  task automatic test_streaming_tail();
    set_map_size(10, 6);
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    send_random(TAIL_ITEMS);
  endtask

  initial begin : main
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_frame();
    test_extreme_windows();
    test_trailing_edges();
    test_degenerate_sizes();
    test_largest_sizes();
    test_restart_on_write();
    test_output_hold();
    test_sender_drain();
    test_random_frames();
    test_streaming_tail();
    quiesce();
    $display("Covered %0d sample words and %0d window means over %0d register writes,",
             samples_sent, means_checked, register_writes);
    $display("with %0d cycles of input held back by a full unit.", input_stalls);
    if (errors == 0 && window_means_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
